// ----- src/pths_pkg.sv -----
package pths_pkg;
   localparam int TIMER_SLOTS = 32;
   localparam int HEAP_DEPTH  = 64;
   localparam int STAMP_BITS  = 16;
   localparam int ID_BITS     = $clog2(TIMER_SLOTS);
   localparam int HADDR_BITS  = $clog2(HEAP_DEPTH);
   localparam int HCNT_BITS   = $clog2(HEAP_DEPTH + 1);
   localparam int TAG_BITS    = ID_BITS + STAMP_BITS;
   localparam int TIME_BITS   = 64;

   typedef enum logic [1:0] {
      OP_REGISTER = 2'd0,
      OP_SET      = 2'd1,
      OP_RELEASE  = 2'd2,
      OP_PUMP     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_FIRED   = 2'd1,
      ST_NOTHING = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]           operation;
      logic [4:0]           timer_id;
      logic [TIME_BITS-1:0] time_value;
      logic [TIME_BITS-1:0] period;
      logic                 keep_period;
      logic                 low_class;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [4:0]           fired_timer;
      logic [TIME_BITS-1:0] fire_time;
      logic [TIME_BITS-1:0] fire_period;
      logic                 fired_low_class;
   } rsp_type;

   // heap entry: deadline then tag, compared as one unsigned key
   typedef struct packed {
      logic [TIME_BITS-1:0] deadline;
      logic [TAG_BITS-1:0]  tag;
   } entry_type;
endpackage

// ----- src/pths_if.sv -----
interface pths_req_if import pths_pkg::*; (input logic clock);
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pths_rsp_if import pths_pkg::*; (input logic clock);
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/periodic_timer_heap_scheduler_unit.sv -----
// Timer heap scheduler. One transaction in, one transaction out. Release reads the
// timer data, then answers; register and set read it, then sift up, each level a
// parent read then a compare/write. A pump removes stale tops and fires a due live
// one (a periodic top moves on by its period, a zero-period one is removed), then
// sifts down, each level reading two children, then compare and write; it answers
// after a fire, an empty heap or a top not yet due. The heap is one synchronous
// memory of deadline/tag entries; timer data is in a second. Timer liveness is a
// register per slot; stamps read zero until first written (a valid bit per slot).
module periodic_timer_heap_scheduler_unit import pths_pkg::*; (
   input logic        clock,
   input logic        reset,
   pths_req_if.sink   req_ch,
   pths_rsp_if.source rsp_ch
);
   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_TRD    = 11'b00000000010,
      S_DISP   = 11'b00000000100,
      S_UPRD   = 11'b00000001000,
      S_UPCMP  = 11'b00000010000,
      S_TOPRD  = 11'b00000100000,
      S_TOPCHK = 11'b00001000000,
      S_LASTRD = 11'b00010000000,
      S_DNRDL  = 11'b00100000000,
      S_DNRDR  = 11'b01000000000,
      S_DNCMP  = 11'b10000000000
   } state_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] period;
      logic [STAMP_BITS-1:0] stamp;
      logic                  low;
   } tinfo_type;

   // memories
   entry_type heap_mem [HEAP_DEPTH];
   tinfo_type tmr_mem  [TIMER_SLOTS];
   logic [TIMER_SLOTS-1:0] alive_ff, alive_in, written_ff, written_in;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [HCNT_BITS-1:0]  count_ff, count_in;
   logic [HADDR_BITS-1:0] idx_ff, idx_in;
   entry_type cur_ff, cur_in, left_ff, left_in;
   tinfo_type tinfo_ff, tinfo_in;
   logic      fired_ff, fired_in;

   // memory ports
   logic                  h_we, h_re;
   logic [HADDR_BITS-1:0] h_waddr, h_raddr;
   entry_type             h_wdata, h_rdata;
   logic                  t_we, t_re;
   logic [ID_BITS-1:0]    t_waddr, t_raddr;
   tinfo_type             t_wdata, t_rdata;

   always_ff @(posedge clock) begin
      if (h_we) heap_mem[h_waddr] <= h_wdata;
      if (h_re) h_rdata <= heap_mem[h_raddr];
      if (t_we) tmr_mem[t_waddr] <= t_wdata;
      if (t_re) t_rdata <= tmr_mem[t_raddr];
   end

   // stamp of a slot never written reads as zero
   tinfo_type t_eff;
   logic [ID_BITS-1:0] top_who;
   logic [ID_BITS-1:0] t_raddr_q;
   always_comb begin
      t_eff = t_rdata;
      if (!written_ff[t_raddr_q]) t_eff.stamp = '0;
   end
   always_ff @(posedge clock) begin
      if (t_re) t_raddr_q <= t_raddr;
   end
   assign top_who = cur_ff.tag[TAG_BITS-1 -: ID_BITS];

   logic [HADDR_BITS:0] lchild, rchild;
   logic [TIME_BITS:0]  sum;
   logic                heap_full;
   assign lchild    = {idx_ff, 1'b1};
   assign rchild    = lchild + 1'b1;
   assign heap_full = (count_ff == HCNT_BITS'(HEAP_DEPTH));
   assign sum       = {1'b0, cur_ff.deadline} + {1'b0, t_eff.period};

   assign req_ch.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   always_comb begin
      state_in = state_ff; req_in = req_ff; rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      count_in = count_ff; idx_in = idx_ff; cur_in = cur_ff; left_in = left_ff;
      tinfo_in = tinfo_ff; fired_in = fired_ff;
      alive_in = alive_ff; written_in = written_ff;
      h_we = 1'b0; h_re = 1'b0; h_waddr = '0; h_raddr = '0; h_wdata = cur_ff;
      t_we = 1'b0; t_re = 1'b0; t_waddr = '0; t_raddr = '0; t_wdata = tinfo_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid && !rsp_valid_ff) begin
               req_in = req_ch.payload;
               rsp_in = '0;
               fired_in = 1'b0;
               t_re = 1'b1;
               t_raddr = req_ch.payload.timer_id[ID_BITS-1:0];
               if (req_ch.payload.operation == OP_PUMP) begin
                  rsp_in.status = ST_NOTHING;
                  state_in = S_TOPRD;
               end else begin
                  state_in = S_TRD;
               end
            end
         end
         S_TRD: state_in = S_DISP;
         S_DISP: begin
            tinfo_in = t_eff;
            state_in = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in.status = ST_DONE;
            case (req_ff.operation)
               OP_RELEASE: alive_in[req_ff.timer_id[ID_BITS-1:0]] = 1'b0;
               OP_REGISTER, OP_SET: begin
                  if (req_ff.operation == OP_SET &&
                      !alive_ff[req_ff.timer_id[ID_BITS-1:0]]) begin
                     rsp_in.status = ST_DONE;
                  end else if (heap_full) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     tinfo_in.stamp = t_eff.stamp + 1'b1;
                     if (req_ff.operation == OP_REGISTER) begin
                        tinfo_in.low = req_ff.low_class;
                        alive_in[req_ff.timer_id[ID_BITS-1:0]] = 1'b1;
                     end
                     if (!(req_ff.operation == OP_SET && req_ff.keep_period))
                        tinfo_in.period = req_ff.period;
                     written_in[req_ff.timer_id[ID_BITS-1:0]] = 1'b1;
                     t_we = 1'b1;
                     t_waddr = req_ff.timer_id[ID_BITS-1:0];
                     t_wdata = tinfo_in;
                     cur_in.deadline = req_ff.time_value;
                     cur_in.tag = {req_ff.timer_id[ID_BITS-1:0], tinfo_in.stamp};
                     idx_in = count_ff[HADDR_BITS-1:0];
                     count_in = count_ff + 1'b1;
                     rsp_valid_in = 1'b0;
                     state_in = S_UPRD;
                  end
               end
               default: ;
            endcase
         end
         // sift up: hole at idx_ff holding cur_ff
         S_UPRD: begin
            if (idx_ff == '0) begin
               h_we = 1'b1; h_waddr = idx_ff;
               rsp_valid_in = 1'b1; state_in = S_IDLE;
            end else begin
               h_re = 1'b1;
               h_raddr = HADDR_BITS'((idx_ff - 1'b1) >> 1);
               state_in = S_UPCMP;
            end
         end
         S_UPCMP: begin
            if (cur_ff < h_rdata) begin
               h_we = 1'b1; h_waddr = idx_ff; h_wdata = h_rdata;
               idx_in = HADDR_BITS'((idx_ff - 1'b1) >> 1);
               state_in = S_UPRD;
            end else begin
               h_we = 1'b1; h_waddr = idx_ff;
               rsp_valid_in = 1'b1; state_in = S_IDLE;
            end
         end
         // pump: fetch top and its timer
         S_TOPRD: begin
            if (count_ff == '0 || fired_ff) begin
               rsp_valid_in = 1'b1; state_in = S_IDLE;
            end else begin
               h_re = 1'b1; h_raddr = '0;
               state_in = S_TOPCHK;
            end
         end
         S_TOPCHK: begin
            cur_in = h_rdata;
            if (req_ff.time_value < h_rdata.deadline) begin
               rsp_valid_in = 1'b1; state_in = S_IDLE;
            end else begin
               t_re = 1'b1;
               t_raddr = h_rdata.tag[TAG_BITS-1 -: ID_BITS];
               h_re = 1'b1; h_raddr = HADDR_BITS'(count_ff - 1'b1);
               state_in = S_LASTRD;
            end
         end
         S_LASTRD: begin
            tinfo_in = t_eff;
            idx_in = '0;
            if (!alive_ff[top_who] ||
                t_eff.stamp != cur_ff.tag[STAMP_BITS-1:0] || t_eff.period == '0) begin
               // remove top: last entry sifts down from root
               if (alive_ff[top_who] && t_eff.stamp == cur_ff.tag[STAMP_BITS-1:0])
                  fired_in = 1'b1;
               count_in = count_ff - 1'b1;
               cur_in = h_rdata;
            end else begin
               fired_in = 1'b1;
               cur_in.deadline = (sum[TIME_BITS]) ? '1 : sum[TIME_BITS-1:0];
            end
            if (fired_in) begin
               rsp_in.status = ST_FIRED;
               rsp_in.fired_timer = 5'(top_who);
               rsp_in.fire_time = req_ff.time_value;
               rsp_in.fire_period = t_eff.period;
               rsp_in.fired_low_class = t_eff.low;
            end
            state_in = S_DNRDL;
         end
         // sift down: hole at idx_ff holding cur_ff, count_ff valid entries
         S_DNRDL: begin
            if (count_ff == '0) begin
               state_in = S_TOPRD;
            end else if (lchild >= (HADDR_BITS+1)'(count_ff)) begin
               h_we = 1'b1; h_waddr = idx_ff; state_in = S_TOPRD;
            end else begin
               h_re = 1'b1; h_raddr = lchild[HADDR_BITS-1:0];
               state_in = S_DNRDR;
            end
         end
         S_DNRDR: begin
            left_in = h_rdata;
            h_re = 1'b1; h_raddr = rchild[HADDR_BITS-1:0];
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            if (rchild < (HADDR_BITS+1)'(count_ff) && h_rdata < left_ff &&
                h_rdata < cur_ff) begin
               h_we = 1'b1; h_waddr = idx_ff; h_wdata = h_rdata;
               idx_in = rchild[HADDR_BITS-1:0];
               state_in = S_DNRDL;
            end else if (left_ff < cur_ff) begin
               h_we = 1'b1; h_waddr = idx_ff; h_wdata = left_ff;
               idx_in = lchild[HADDR_BITS-1:0];
               state_in = S_DNRDL;
            end else begin
               h_we = 1'b1; h_waddr = idx_ff; state_in = S_TOPRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid_ff <= 1'b0; count_ff <= '0;
         alive_ff <= '0; written_ff <= '0; fired_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rsp_valid_ff <= rsp_valid_in; count_ff <= count_in;
         alive_ff <= alive_in; written_ff <= written_in; fired_ff <= fired_in;
      end
      req_ff <= req_in; rsp_ff <= rsp_in; idx_ff <= idx_in; cur_ff <= cur_in;
      left_ff <= left_in; tinfo_ff <= tinfo_in;
   end

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= HCNT_BITS'(HEAP_DEPTH)) else $error("heap count overflow");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ch.ready) else $error("ready while busy");
   a_fire_pump: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ST_FIRED) |-> (req_ff.operation == OP_PUMP))
      else $error("fire outside pump");
endmodule
